// ===== hw/rtl/fcsm_pkg.sv =====
// ----------------------------------------------------------------------------
// fcsm_pkg
// Shared types and constants of the floor and ceiling span mapper: opcodes,
// draw modes, item layouts and texture store geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package fcsm_pkg;

  // texture store geometry, ceiling and floor texels interleaved
  localparam int unsigned TEX_AW     = 13;
  localparam int unsigned TEX_DEPTH  = 1 << TEX_AW;
  localparam int unsigned BANK_AW    = TEX_AW - 1;
  localparam int unsigned BANK_DEPTH = TEX_DEPTH / 2;

  // shading table
  localparam int unsigned SHADE_AW    = 8;
  localparam int unsigned SHADE_DEPTH = 1 << SHADE_AW;

  // row state widths
  localparam int unsigned COUNT_BITS = 12;
  localparam int unsigned HALF_W     = 16;
  localparam int unsigned COORD_W    = 2 * HALF_W;
  localparam int unsigned SCR_W      = 16;
  localparam int unsigned PIX_W      = 8;

  // texel index bits taken from each coordinate
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned IDX_LO = HALF_W - IDX_W;

  typedef enum logic [1:0] {
    OP_LOAD_TEX   = 2'd0,
    OP_LOAD_SHADE = 2'd1,
    OP_START_ROW  = 2'd2,
    OP_DRAW       = 2'd3
  } fcsm_op_e;

  typedef enum logic [1:0] {
    MODE_CEIL  = 2'd0,
    MODE_FLOOR = 2'd1,
    MODE_BOTH  = 2'd2,
    MODE_NONE  = 2'd3
  } fcsm_mode_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [TEX_AW-1:0] table_addr;
    logic [PIX_W-1:0]  table_data;
    logic [HALF_W-1:0] x_frac;
    logic [HALF_W-1:0] y_frac;
    logic [HALF_W-1:0] x_step;
    logic [HALF_W-1:0] y_step;
    logic [SCR_W-1:0]  dest_addr;
    logic [SCR_W-1:0]  row_offset;
    logic [11:0]       pixel_count;
    logic [1:0]        draw_mode;
    logic              shade_enable;
  } fcsm_req_t;

  typedef struct packed {
    logic             ceil_write;
    logic [SCR_W-1:0] ceil_addr;
    logic [PIX_W-1:0] ceil_pixel;
    logic             floor_write;
    logic [SCR_W-1:0] floor_addr;
    logic [PIX_W-1:0] floor_pixel;
    logic             last_in_row;
  } fcsm_rsp_t;

  // write request into the texture store
  typedef struct packed {
    logic               we;
    logic               odd;
    logic [BANK_AW-1:0] idx;
    logic [PIX_W-1:0]   data;
  } fcsm_tex_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fcsm_req_if.sv =====
// ----------------------------------------------------------------------------
// fcsm_req_if
// Command channel of the span mapper: valid, ready and one command item.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcsm_req_if;
  logic                valid;
  logic                ready;
  fcsm_pkg::fcsm_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fcsm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fcsm_rsp_if
// Pixel write channel of the span mapper: valid, ready and one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface fcsm_rsp_if;
  logic                valid;
  logic                ready;
  fcsm_pkg::fcsm_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/floor_ceiling_span_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// floor_ceiling_span_mapper_unit
// Throughput: one item per cycle; the texture read, the shade table read and
// the output register form a three stage pipeline that stalls as a whole only
// when the output register is full and not taken.
// Reset: row state and pipeline valid bits clear at once; the texture store
// and shade table are not cleared and hold garbage until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module floor_ceiling_span_mapper_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fcsm_req_if.sink   in_i,
  fcsm_rsp_if.source out_o
);
  import fcsm_pkg::*;

  // pipeline stage contents
  typedef struct packed {
    logic             ceil_write;
    logic             floor_write;
    logic [SCR_W-1:0] ceil_addr;
    logic [SCR_W-1:0] floor_addr;
    logic             last_in_row;
    logic             shade;
  } pix_ctl_t;

  logic advance;
  logic accept;
  logic op_tex, op_shade, op_start, op_draw, draw_hit;
  fcsm_op_e   op;
  fcsm_mode_e mode;

  // row state
  logic [COORD_W-1:0]    coord_accum_q, coord_accum_d;
  logic [COORD_W-1:0]    coord_step_q, coord_step_d;
  logic [SCR_W-1:0]      screen_pos_q, screen_pos_d;
  logic [SCR_W-1:0]      floor_offset_q, floor_offset_d;
  logic [COUNT_BITS-1:0] pixels_left_q, pixels_left_d;
  logic [1:0]            row_mode_q, row_mode_d;
  logic                  row_shade_q, row_shade_d;

  // pipeline registers
  logic     s1_valid_q, s2_valid_q, out_valid_q;
  pix_ctl_t s1_ctl_q, s1_ctl_d, s2_ctl_q;
  logic [PIX_W-1:0] s2_ceil_raw_q, s2_floor_raw_q;
  logic [PIX_W-1:0] s2_ceil_sh_q, s2_floor_sh_q;
  fcsm_rsp_t out_q, out_d;

  // memories
  fcsm_tex_wr_t       tex_wr;
  logic [BANK_AW-1:0] tex_rd_idx;
  logic [PIX_W-1:0]   tex_ceil, tex_floor;
  logic [PIX_W-1:0]   shade_mem [SHADE_DEPTH];
  logic [PIX_W-1:0]   ceil_pix, floor_pix;

  // handshake: the whole pipeline moves unless the output is blocked
  assign advance     = !out_valid_q || out_o.ready;
  assign in_i.ready  = advance;
  assign accept      = in_i.valid && advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // command decode
  always_comb begin
    op       = fcsm_op_e'(in_i.data.opcode);
    op_tex   = 1'b0;
    op_shade = 1'b0;
    op_start = 1'b0;
    op_draw  = 1'b0;
    unique case (op)
      OP_LOAD_TEX:   op_tex   = accept;
      OP_LOAD_SHADE: op_shade = accept;
      OP_START_ROW:  op_start = accept;
      OP_DRAW:       op_draw  = accept;
      default:       op_draw  = 1'b0;
    endcase
  end

  assign draw_hit = op_draw && (pixels_left_q != '0);

  // row state update
  always_comb begin
    coord_accum_d  = coord_accum_q;
    coord_step_d   = coord_step_q;
    screen_pos_d   = screen_pos_q;
    floor_offset_d = floor_offset_q;
    pixels_left_d  = pixels_left_q;
    row_mode_d     = row_mode_q;
    row_shade_d    = row_shade_q;
    if (op_start) begin
      coord_accum_d  = {in_i.data.y_frac, in_i.data.x_frac};
      coord_step_d   = {in_i.data.y_step, in_i.data.x_step};
      screen_pos_d   = in_i.data.dest_addr;
      floor_offset_d = in_i.data.row_offset;
      pixels_left_d  = COUNT_BITS'(in_i.data.pixel_count);
      row_mode_d     = in_i.data.draw_mode;
      row_shade_d    = in_i.data.shade_enable;
    end else if (draw_hit) begin
      coord_accum_d = coord_accum_q + coord_step_q;
      screen_pos_d  = screen_pos_q + SCR_W'(1);
      pixels_left_d = pixels_left_q - COUNT_BITS'(1);
    end
  end

  // pixel control for the first stage
  always_comb begin
    mode                 = fcsm_mode_e'(row_mode_q);
    s1_ctl_d.ceil_write  = (mode == MODE_CEIL) || (mode == MODE_BOTH);
    s1_ctl_d.floor_write = (mode == MODE_FLOOR) || (mode == MODE_BOTH);
    s1_ctl_d.ceil_addr   = s1_ctl_d.ceil_write ? screen_pos_q : '0;
    s1_ctl_d.floor_addr  = s1_ctl_d.floor_write ? (screen_pos_q + floor_offset_q) : '0;
    s1_ctl_d.last_in_row = (pixels_left_q == COUNT_BITS'(1));
    s1_ctl_d.shade       = row_shade_q;
  end

  // texture store access: x index in the high bits, y index next
  assign tex_wr.we   = op_tex;
  assign tex_wr.odd  = in_i.data.table_addr[0];
  assign tex_wr.idx  = in_i.data.table_addr[TEX_AW-1:1];
  assign tex_wr.data = in_i.data.table_data;
  assign tex_rd_idx  = {coord_accum_q[IDX_LO +: IDX_W],
                        coord_accum_q[HALF_W + IDX_LO +: IDX_W]};

  fcsm_tex_store u_tex_store (
    .clk_i        (clk_i),
    .wr_i         (tex_wr),
    .rd_en_i      (advance),
    .rd_idx_i     (tex_rd_idx),
    .ceil_texel_o (tex_ceil),
    .floor_texel_o(tex_floor)
  );

  // shade table: written by load items, read by the second stage
  always_ff @(posedge clk_i) begin
    if (op_shade) begin
      shade_mem[in_i.data.table_addr[SHADE_AW-1:0]] <= in_i.data.table_data;
    end
    if (advance) begin
      s2_ceil_sh_q  <= shade_mem[tex_ceil];
      s2_floor_sh_q <= shade_mem[tex_floor];
    end
  end

  // final pixel selection, unused sides forced to zero
  always_comb begin
    ceil_pix  = s2_ctl_q.shade ? s2_ceil_sh_q : s2_ceil_raw_q;
    floor_pix = s2_ctl_q.shade ? s2_floor_sh_q : s2_floor_raw_q;
    out_d.ceil_write  = s2_ctl_q.ceil_write;
    out_d.ceil_addr   = s2_ctl_q.ceil_addr;
    out_d.ceil_pixel  = s2_ctl_q.ceil_write ? ceil_pix : '0;
    out_d.floor_write = s2_ctl_q.floor_write;
    out_d.floor_addr  = s2_ctl_q.floor_addr;
    out_d.floor_pixel = s2_ctl_q.floor_write ? floor_pix : '0;
    out_d.last_in_row = s2_ctl_q.last_in_row;
  end

  // control state and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_accum_q  <= '0;
      coord_step_q   <= '0;
      screen_pos_q   <= '0;
      floor_offset_q <= '0;
      pixels_left_q  <= '0;
      row_mode_q     <= '0;
      row_shade_q    <= 1'b0;
      s1_valid_q     <= 1'b0;
      s2_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      coord_accum_q  <= coord_accum_d;
      coord_step_q   <= coord_step_d;
      screen_pos_q   <= screen_pos_d;
      floor_offset_q <= floor_offset_d;
      pixels_left_q  <= pixels_left_d;
      row_mode_q     <= row_mode_d;
      row_shade_q    <= row_shade_d;
      if (advance) begin
        s1_valid_q  <= draw_hit;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_ctl_q       <= s1_ctl_d;
      s2_ctl_q       <= s1_ctl_q;
      s2_ceil_raw_q  <= tex_ceil;
      s2_floor_raw_q <= tex_floor;
      out_q          <= out_d;
    end
  end

`ifndef SYNTHESIS
  // a draw on an empty row leaves the count empty and issues nothing
  a_empty_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_draw && pixels_left_q == '0) |=> (pixels_left_q == '0 && !s1_valid_q))
    else $error("draw on empty row changed state");

  // a draw on the final pixel empties the row and flags it last
  a_last_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_draw && pixels_left_q == COUNT_BITS'(1)) |=>
      (pixels_left_q == '0 && s1_valid_q && s1_ctl_q.last_in_row))
    else $error("last pixel not flagged");

  // a blocked output freezes the pipeline contents
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(s1_valid_q) && $stable(s2_valid_q) && $stable(out_q)))
    else $error("pipeline moved during stall");

  // a disabled ceiling side carries zero address and pixel
  a_zero_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.ceil_write) |-> (out_q.ceil_addr == '0 && out_q.ceil_pixel == '0))
    else $error("unused ceiling fields not zero");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/fcsm_tex_store.sv =====
// ----------------------------------------------------------------------------
// fcsm_tex_store
// Texture store split into an even bank (ceiling texels) and an odd bank
// (floor texels), so both texels of a pixel come out in one read.
// ----------------------------------------------------------------------------
`default_nettype none

module fcsm_tex_store (
  input  wire logic                         clk_i,
  input  wire fcsm_pkg::fcsm_tex_wr_t       wr_i,
  input  wire logic                         rd_en_i,
  input  wire logic [fcsm_pkg::BANK_AW-1:0] rd_idx_i,
  output logic      [fcsm_pkg::PIX_W-1:0]   ceil_texel_o,
  output logic      [fcsm_pkg::PIX_W-1:0]   floor_texel_o
);
  import fcsm_pkg::*;

  logic [PIX_W-1:0] even_mem [BANK_DEPTH];
  logic [PIX_W-1:0] odd_mem  [BANK_DEPTH];

  // bank writes, selected by the low address bit
  always_ff @(posedge clk_i) begin
    if (wr_i.we && !wr_i.odd) begin
      even_mem[wr_i.idx] <= wr_i.data;
    end
    if (wr_i.we && wr_i.odd) begin
      odd_mem[wr_i.idx] <= wr_i.data;
    end
  end

  // registered read of both banks, held while the pipeline stalls
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      ceil_texel_o  <= even_mem[rd_idx_i];
      floor_texel_o <= odd_mem[rd_idx_i];
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the floor and ceiling span mapper. Commands load
// the texture store and shading table, start rows and draw pixels; a local
// predictor tracks the row state and both tables and queues the pixel write
// each draw should give. Table entries are loaded on demand before a draw
// can read them. Directed edge cases come first, then random spans under
// three sender and receiver stall profiles.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import fcsm_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;

  fcsm_req_if cmd_if ();
  fcsm_rsp_if pix_if ();

  floor_ceiling_span_mapper_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (pix_if)
  );

  // predictor copy of the tables and the row state
  logic [PIX_W-1:0]      tex_mem   [TEX_DEPTH];
  bit                    tex_ok    [TEX_DEPTH];
  logic [PIX_W-1:0]      shade_mem [SHADE_DEPTH];
  bit                    shade_ok  [SHADE_DEPTH];
  logic [COORD_W-1:0]    coord_acc;
  logic [COORD_W-1:0]    coord_inc;
  logic [SCR_W-1:0]      scr_pos;
  logic [SCR_W-1:0]      flr_off;
  logic [COUNT_BITS-1:0] pixels_left;
  fcsm_mode_e            span_mode;
  logic                  span_shade;

  fcsm_rsp_t pixel_writes_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          items_sent;
  bit          failed;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

  // predictor update for one accepted item, queueing the expected pixel write of a draw
  function automatic void predict_span_item(input fcsm_req_t it);
    fcsm_rsp_t          wr;
    logic [TEX_AW-1:0]  base;
    logic [PIX_W-1:0]   texel;
    case (it.opcode)
      OP_LOAD_TEX: begin
        tex_mem[it.table_addr] = it.table_data;
        tex_ok[it.table_addr]  = 1'b1;
      end
      OP_LOAD_SHADE: begin
        shade_mem[it.table_addr[SHADE_AW-1:0]] = it.table_data;
        shade_ok[it.table_addr[SHADE_AW-1:0]]  = 1'b1;
      end
      OP_START_ROW: begin
        coord_acc   = {it.y_frac, it.x_frac};
        coord_inc   = {it.y_step, it.x_step};
        scr_pos     = it.dest_addr;
        flr_off     = it.row_offset;
        pixels_left = it.pixel_count[COUNT_BITS-1:0];
        span_mode   = fcsm_mode_e'(it.draw_mode);
        span_shade  = it.shade_enable;
      end
      default: begin
        if (pixels_left != '0) begin
          // x index in the high bits, y index below, even byte for ceiling
          base = {coord_acc[HALF_W-1:IDX_LO], coord_acc[COORD_W-1:HALF_W+IDX_LO], 1'b0};
          wr   = '0;
          if (span_mode == MODE_CEIL || span_mode == MODE_BOTH) begin
            texel         = tex_mem[base];
            wr.ceil_write = 1'b1;
            wr.ceil_addr  = scr_pos;
            wr.ceil_pixel = span_shade ? shade_mem[texel] : texel;
          end
          if (span_mode == MODE_FLOOR || span_mode == MODE_BOTH) begin
            texel          = tex_mem[{base[TEX_AW-1:1], 1'b1}];
            wr.floor_write = 1'b1;
            wr.floor_addr  = scr_pos + flr_off;
            wr.floor_pixel = span_shade ? shade_mem[texel] : texel;
          end
          coord_acc      = coord_acc + coord_inc;
          scr_pos        = scr_pos + 1'b1;
          pixels_left    = pixels_left - 1'b1;
          wr.last_in_row = (pixels_left == '0);
          pixel_writes_q.push_back(wr);
        end
      end
    endcase
  endfunction

  // every field random, callers overwrite what matters
  function automatic fcsm_req_t rand_item();
    logic [159:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return r[$bits(fcsm_req_t)-1:0];
  endfunction

  // send one item, with optional idle cycles ahead of it
  task automatic send_item(input fcsm_req_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= it;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    if (!(it.opcode == OP_DRAW && pixels_left == '0)) items_sent++;
    predict_span_item(it);
  endtask

  task automatic load_texel(input logic [TEX_AW-1:0] addr, input logic [PIX_W-1:0] val);
    fcsm_req_t it;
    it            = rand_item();
    it.opcode     = OP_LOAD_TEX;
    it.table_addr = addr;
    it.table_data = val;
    send_item(it);
  endtask

  task automatic load_shade(input logic [TEX_AW-1:0] addr, input logic [PIX_W-1:0] val);
    fcsm_req_t it;
    it            = rand_item();
    it.opcode     = OP_LOAD_SHADE;
    it.table_addr = addr;
    it.table_data = val;
    send_item(it);
  endtask

  task automatic start_row(input logic [HALF_W-1:0] x0, input logic [HALF_W-1:0] y0,
                           input logic [HALF_W-1:0] dx, input logic [HALF_W-1:0] dy,
                           input logic [SCR_W-1:0] dest, input logic [SCR_W-1:0] offs,
                           input logic [11:0] count, input fcsm_mode_e mode,
                           input logic shade);
    fcsm_req_t it;
    it              = rand_item();
    it.opcode       = OP_START_ROW;
    it.x_frac       = x0;
    it.y_frac       = y0;
    it.x_step       = dx;
    it.y_step       = dy;
    it.dest_addr    = dest;
    it.row_offset   = offs;
    it.pixel_count  = count;
    it.draw_mode    = mode;
    it.shade_enable = shade;
    send_item(it);
  endtask

  // draw one pixel, first loading any table entry it would read unwritten
  task automatic draw_pixel();
    fcsm_req_t         it;
    logic [TEX_AW-1:0] addr;
    int                k;
    if (pixels_left != '0) begin
      for (k = 0; k < 2; k++) begin
        addr = {coord_acc[HALF_W-1:IDX_LO], coord_acc[COORD_W-1:HALF_W+IDX_LO], k[0]};
        if (!tex_ok[addr]) load_texel(addr, PIX_W'($urandom));
        if (span_shade && !shade_ok[tex_mem[addr]])
          load_shade({5'($urandom), tex_mem[addr]}, PIX_W'($urandom));
      end
    end
    it        = rand_item();
    it.opcode = OP_DRAW;
    send_item(it);
  endtask

  // hold the sender until every pending pixel write has come out
  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pixel_writes_q.size() != 0) @(posedge clk_i);
  endtask

  // extreme table addresses, index masking of the shade load, shaded draw
  task automatic test_table_extremes();
    load_texel(13'h0000, 8'hFF);
    load_texel(13'h1FFF, 8'h00);
    load_shade(13'h1FFF, 8'h00);
    load_shade(13'h0000, 8'hFF);
    start_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd1,
              MODE_BOTH, 1'b1);
    draw_pixel();
  endtask

  // x carry into y, accumulator and screen address wrap, top texel indexes
  task automatic test_carry_and_wrap();
    start_row(16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'd2,
              MODE_BOTH, 1'b0);
    draw_pixel();
    draw_pixel();
  endtask

  // ceiling only, floor only and no-write mode
  task automatic test_draw_modes();
    start_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h1234, 16'h0140, 12'd1,
              MODE_CEIL, 1'b0);
    draw_pixel();
    start_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 12'd1,
              MODE_FLOOR, 1'b0);
    draw_pixel();
    start_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hABCD, 16'h0001, 12'd1,
              MODE_NONE, 1'b0);
    draw_pixel();
  endtask

  // draws with no row pending, including after a zero-length row
  task automatic test_idle_draws();
    draw_pixel();
    start_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 12'd0,
              MODE_BOTH, 1'b0);
    draw_pixel();
  endtask

  // largest pixel count, row cut short by a new start
  task automatic test_full_count();
    start_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFE, 16'h0002, 12'hFFF,
              MODE_BOTH, 1'b1);
    draw_pixel();
    draw_pixel();
    start_row(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0010, 16'h0100, 12'd1,
              MODE_BOTH, 1'b1);
    draw_pixel();
  endtask

  // random rows with stray table writes, idle draws and drains mixed in
  task automatic run_random_spans(input int n_items);
    fcsm_req_t             it;
    int                    stop_at;
    int                    n_draw;
    int                    choice;
    int                    i;
    logic [COUNT_BITS-1:0] count;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      choice = $urandom_range(99);
      if (choice < 6) begin
        load_texel(TEX_AW'($urandom), PIX_W'($urandom));
      end else if (choice < 9) begin
        load_shade(TEX_AW'($urandom), PIX_W'($urandom));
      end else if (choice < 12) begin
        draw_pixel();
      end else if (choice < 14) begin
        drain_results();
      end else begin
        choice = $urandom_range(99);
        if (choice < 5) count = '0;
        else if (choice < 9) count = COUNT_BITS'($urandom_range(25, 4095));
        else count = COUNT_BITS'($urandom_range(1, 24));
        it             = rand_item();
        it.opcode      = OP_START_ROW;
        it.pixel_count = count;
        send_item(it);
        n_draw = (count <= 24) ? int'(count) : $urandom_range(1, 24);
        for (i = 0; i < n_draw; i++) begin
          draw_pixel();
          if ($urandom_range(99) < 4) load_texel(TEX_AW'($urandom), PIX_W'($urandom));
          if ($urandom_range(99) < 2) break;
        end
        if ($urandom_range(9) == 0) draw_pixel();
      end
    end
  endtask

  // receiver stalls
  always @(posedge clk_i) begin
    pix_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // compare one field of a pixel write
  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: pixel write %s mismatch: expected %0h, actual %0h",
               $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  // check each pixel write against the oldest prediction
  always @(posedge clk_i) begin : pixel_check
    fcsm_rsp_t want;
    fcsm_rsp_t got;
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      got = pix_if.data;
      if (pixel_writes_q.size() == 0) begin
        $display("%0t: unexpected pixel write: expected none, actual %h", $time, got);
        failed = 1'b1;
      end else begin
        want = pixel_writes_q.pop_front();
        check_field("ceil_write",  16'(want.ceil_write),  16'(got.ceil_write));
        check_field("ceil_addr",   want.ceil_addr,        got.ceil_addr);
        check_field("ceil_pixel",  16'(want.ceil_pixel),  16'(got.ceil_pixel));
        check_field("floor_write", 16'(want.floor_write), 16'(got.floor_write));
        check_field("floor_addr",  want.floor_addr,       got.floor_addr);
        check_field("floor_pixel", 16'(want.floor_pixel), 16'(got.floor_pixel));
        check_field("last_in_row", 16'(want.last_in_row), 16'(got.last_in_row));
      end
    end
  end

  // test sequence
  initial begin
    rst_ni        = 1'b0;
    cmd_if.valid  = 1'b0;
    cmd_if.data   = '0;
    send_idle_pct = 12;
    recv_idle_pct = 84;
    items_sent    = 0;
    failed        = 1'b0;
    coord_acc     = '0;
    coord_inc     = '0;
    scr_pos       = '0;
    flr_off       = '0;
    pixels_left   = '0;
    span_mode     = MODE_CEIL;
    span_shade    = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_table_extremes();
    test_carry_and_wrap();
    test_draw_modes();
    test_idle_draws();
    test_full_count();

    drain_results();
    run_random_spans(624);

    send_idle_pct = 84;
    recv_idle_pct = 12;
    drain_results();
    run_random_spans(624);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_results();
    run_random_spans(624);

    cmd_if.valid <= 1'b0;
    while (pixel_writes_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (!failed) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
